// ===== src/hrbt_pkg.sv =====
`timescale 1ns / 1ps

package hrbt_pkg;

  // Default width of the decoded length and the body counter
  localparam int LengthBitsDef = 32;

  // Fixed field widths
  localparam int ByteW  = 8;
  localparam int BlenW  = 32;
  localparam int TdataW = 48;

  // Reset value of the max body length register
  localparam logic [31:0] MaxBodyRst = 32'd2147483647;

  // Match strings
  localparam int PolicyLen = 22;
  localparam int ClenLen   = 14;
  localparam logic [8*PolicyLen-1:0] PolicyStr = "<policy-file-request/>";
  localparam logic [8*ClenLen-1:0]   ClenStr   = "Content-Length";

  // Delimiter characters
  localparam logic [7:0] ChQuest = 8'h3f;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Parser phases, one-hot
  typedef enum logic [10:0] {
    PhMethod = 11'b000_0000_0001,
    PhPath   = 11'b000_0000_0010,
    PhArgKey = 11'b000_0000_0100,
    PhArgVal = 11'b000_0000_1000,
    PhVer    = 11'b000_0001_0000,
    PhHdrKey = 11'b000_0010_0000,
    PhHdrVal = 11'b000_0100_0000,
    PhBody   = 11'b000_1000_0000,
    PhDone   = 11'b001_0000_0000,
    PhPolicy = 11'b010_0000_0000,
    PhBad    = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    TagMethod = 4'd0,
    TagPath   = 4'd1,
    TagArgKey = 4'd2,
    TagArgVal = 4'd3,
    TagVer    = 4'd4,
    TagHdrKey = 4'd5,
    TagHdrVal = 4'd6,
    TagBody   = 4'd7,
    TagSkip   = 4'd8
  } tag_e;

  typedef enum logic [1:0] {
    CmtNone   = 2'd0,
    CmtArg    = 2'd1,
    CmtHdr    = 2'd2,
    CmtHdrEnd = 2'd3
  } commit_e;

  typedef enum logic [1:0] {
    StParsing = 2'd0,
    StDone    = 2'd1,
    StPolicy  = 2'd2,
    StBadLen  = 2'd3
  } status_e;

  // One result beat
  typedef struct packed {
    logic [BlenW-1:0] blen;
    status_e          status;
    commit_e          commit;
    tag_e             tag;
    logic [ByteW-1:0] data;
  } res_t;

  // Core to length unit
  typedef struct packed {
    logic clear;
    logic digit;
    logic body;
  } len_ctrl_t;

  // Length unit to core
  typedef struct packed {
    logic bad;
    logic has_digit;
    logic body_done;
  } len_stat_t;

  function automatic logic [7:0] policy_char(input logic [4:0] idx);
    int pos;
    pos = PolicyLen - 1 - int'(idx);
    if (pos < 0) pos = 0;
    return PolicyStr[8*pos +: 8];
  endfunction

  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    int pos;
    pos = ClenLen - 1 - int'(idx);
    if (pos < 0) pos = 0;
    return ClenStr[8*pos +: 8];
  endfunction

endpackage

// ===== src/hrbt_len.sv =====
`timescale 1ns / 1ps

module hrbt_len import hrbt_pkg::*; #(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  len_ctrl_t              ctrl_i,
  input  logic [ByteW-1:0]       byte_i,
  input  logic [31:0]            max_body_i,
  output logic [LENGTH_BITS-1:0] value_o,
  output len_stat_t              stat_o
);

  // Compare width covers both the register and the length field plus x10 growth
  localparam int BaseW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam int CW    = BaseW + 4;

  logic [LENGTH_BITS-1:0] value_q, value_d;
  logic [LENGTH_BITS-1:0] count_q, count_d, count_inc;
  logic                   bad_q, bad_d;
  logic                   has_q, has_d;

  logic [CW-1:0] mask_w, maxb_w, limit_w, acc_w;
  logic          is_digit;
  logic [3:0]    digit;

  // Limit is the smaller of the register and the field range
  assign mask_w  = CW'({LENGTH_BITS{1'b1}});
  assign maxb_w  = CW'(max_body_i);
  assign limit_w = (maxb_w < mask_w) ? maxb_w : mask_w;

  // value * 10 + digit as shift-add
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit    = 4'(byte_i - ChZero);
  assign acc_w    = (CW'(value_q) << 3) + (CW'(value_q) << 1) + CW'(digit);

  assign count_inc = count_q + LENGTH_BITS'(1);

  always_comb begin
    value_d = value_q;
    count_d = count_q;
    bad_d   = bad_q;
    has_d   = has_q;
    if (ctrl_i.clear) begin
      value_d = '0;
      count_d = '0;
      bad_d   = 1'b0;
      has_d   = 1'b0;
    end else begin
      if (ctrl_i.digit) begin
        if (!is_digit) begin
          bad_d = 1'b1;
        end else begin
          has_d = 1'b1;
          if (!bad_q) begin
            if (acc_w > limit_w) bad_d = 1'b1;
            else value_d = LENGTH_BITS'(acc_w);
          end
        end
      end
      if (ctrl_i.body) count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
      has_q   <= 1'b0;
    end else begin
      value_q <= value_d;
      count_q <= count_d;
      bad_q   <= bad_d;
      has_q   <= has_d;
    end
  end

  assign value_o          = value_q;
  assign stat_o.bad       = bad_q;
  assign stat_o.has_digit = has_q;
  assign stat_o.body_done = (count_inc == value_q);

endmodule

// ===== src/hrbt_core.sv =====
`timescale 1ns / 1ps

module hrbt_core import hrbt_pkg::*; #(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             kind_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [31:0]      max_body_i,
  output res_t             res_o
);

  phase_e     phase_q, phase_d;
  logic [4:0] mcount_q, mcount_d;
  logic       mmatch_q, mmatch_d;
  logic [3:0] kcount_q, kcount_d;
  logic       kmatch_q, kmatch_d;
  logic       vlen_q, vlen_d;
  logic       lseen_q, lseen_d;

  len_ctrl_t              lctrl;
  len_stat_t              lstat;
  logic [LENGTH_BITS-1:0] lvalue;
  logic [63:0]            lvalue_w;

  assign lvalue_w = 64'(lvalue);

  hrbt_len #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_len (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lctrl),
    .byte_i     (byte_i),
    .max_body_i (max_body_i),
    .value_o    (lvalue),
    .stat_o     (lstat)
  );

  // Phase transitions and tagging for one byte
  always_comb begin
    phase_d  = phase_q;
    mcount_d = mcount_q;
    mmatch_d = mmatch_q;
    kcount_d = kcount_q;
    kmatch_d = kmatch_q;
    vlen_d   = vlen_q;
    lseen_d  = lseen_q;
    lctrl    = '0;
    res_o.data   = byte_i;
    res_o.tag    = TagSkip;
    res_o.commit = CmtNone;
    res_o.status = StParsing;
    res_o.blen   = '0;
    if (step_i && kind_i) begin
      // new request
      phase_d     = PhMethod;
      mcount_d    = '0;
      mmatch_d    = 1'b1;
      kcount_d    = '0;
      kmatch_d    = 1'b1;
      vlen_d      = 1'b0;
      lseen_d     = 1'b0;
      lctrl.clear = 1'b1;
    end else if (step_i) begin
      unique case (phase_q)
        PhMethod: begin
          if (mmatch_q && (mcount_q == 5'(PolicyLen))) begin
            phase_d      = PhPolicy;
            res_o.status = StPolicy;
          end else if (byte_i == ChSpace) begin
            phase_d = PhPath;
          end else begin
            res_o.tag = TagMethod;
            if (mmatch_q && (mcount_q < 5'(PolicyLen)) &&
                (byte_i == policy_char(mcount_q)))
              mcount_d = mcount_q + 5'd1;
            else
              mmatch_d = 1'b0;
          end
        end
        PhPath: begin
          if (byte_i == ChQuest) phase_d = PhArgKey;
          else if (byte_i == ChSpace) phase_d = PhVer;
          else res_o.tag = TagPath;
        end
        PhArgKey: begin
          if (byte_i == ChEq) phase_d = PhArgVal;
          else if (byte_i == ChSpace) phase_d = PhVer;
          else res_o.tag = TagArgKey;
        end
        PhArgVal: begin
          if (byte_i == ChAmp) begin
            res_o.commit = CmtArg;
            phase_d      = PhArgKey;
          end else if (byte_i == ChSpace) begin
            res_o.commit = CmtArg;
            phase_d      = PhVer;
          end else begin
            res_o.tag = TagArgVal;
          end
        end
        PhVer: begin
          if (byte_i == ChLf) begin
            kcount_d = '0;
            kmatch_d = 1'b1;
            phase_d  = PhHdrKey;
          end else if (byte_i != ChCr) begin
            res_o.tag = TagVer;
          end
        end
        PhHdrKey: begin
          if (byte_i == ChLf) begin
            // blank line ends the headers
            res_o.commit = CmtHdrEnd;
            if (!lseen_q) begin
              res_o.status = StDone;
              phase_d      = PhDone;
            end else if (lstat.bad || !lstat.has_digit) begin
              res_o.status = StBadLen;
              phase_d      = PhBad;
            end else begin
              res_o.blen = lvalue_w[31:0];
              if (lvalue == '0) begin
                res_o.status = StDone;
                phase_d      = PhDone;
              end else begin
                phase_d = PhBody;
              end
            end
          end else if (byte_i == ChSpace) begin
            vlen_d  = !lseen_q && kmatch_q && (kcount_q == 4'(ClenLen));
            phase_d = PhHdrVal;
          end else if ((byte_i != ChCr) && (byte_i != ChColon)) begin
            res_o.tag = TagHdrKey;
            if (kmatch_q && (kcount_q < 4'(ClenLen)) &&
                (byte_i == clen_char(kcount_q)))
              kcount_d = kcount_q + 4'd1;
            else
              kmatch_d = 1'b0;
          end
        end
        PhHdrVal: begin
          if (byte_i == ChLf) begin
            res_o.commit = CmtHdr;
            if (vlen_q) begin
              lseen_d = 1'b1;
              vlen_d  = 1'b0;
            end
            kcount_d = '0;
            kmatch_d = 1'b1;
            phase_d  = PhHdrKey;
          end else if (byte_i != ChCr) begin
            res_o.tag   = TagHdrVal;
            lctrl.digit = vlen_q;
          end
        end
        PhBody: begin
          res_o.tag  = TagBody;
          lctrl.body = 1'b1;
          if (lstat.body_done) begin
            res_o.status = StDone;
            phase_d      = PhDone;
          end
        end
        PhPolicy: res_o.status = StPolicy;
        PhBad:    res_o.status = StBadLen;
        default:  res_o.status = StDone;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMethod;
      mcount_q <= '0;
      mmatch_q <= 1'b1;
      kcount_q <= '0;
      kmatch_q <= 1'b1;
      vlen_q   <= 1'b0;
      lseen_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      mcount_q <= mcount_d;
      mmatch_q <= mmatch_d;
      kcount_q <= kcount_d;
      kmatch_q <= kmatch_d;
      vlen_q   <= vlen_d;
      lseen_q  <= lseen_d;
    end
  end

endmodule

// ===== src/http_request_byte_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// A result beat passes the input register and the result register to the master side.
// Throughput: one byte per cycle while the master side does not stall; the parse
// phase, string match and x10 length accumulate for a byte all settle between the two registers.
// A new-request beat (tuser set) gives no result beat.
// Reset (rst_ni low, asynchronous) clears the parser and sets max_body_length to 2147483647.

module http_request_byte_tokenizer_unit import hrbt_pkg::*; #(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave side
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] in_byte
  input  logic [0:0]        s_axis_tuser_i,   // [0] kind
  // master side
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] commit,
                                              // [11:10] status, [43:12] body_length
  output logic [3:0]        m_axis_tuser_o,   // [3:0] tag
  // config write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  logic             in_vld_q, in_vld_d;
  logic             in_kind_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  res_t             out_res_q;
  res_t             res;
  logic [31:0]      max_body_q;
  logic             advance;
  logic             s_take;

  // Input beat moves on when it is a new-request beat or the result register is free or being drained
  assign advance = in_vld_q && (in_kind_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_take = s_axis_tvalid_i && s_axis_tready_o;

  hrbt_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .kind_i     (in_kind_q),
    .byte_i     (in_byte_q),
    .max_body_i (max_body_q),
    .res_o      (res)
  );

  // Valid flags
  always_comb begin
    in_vld_d = in_vld_q;
    if (s_take) in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (advance && !in_kind_q) out_vld_d = 1'b1;
    else if (m_axis_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      max_body_q <= MaxBodyRst;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) max_body_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_kind_q <= s_axis_tuser_i[0];
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && !in_kind_q) out_res_q <= res;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_res_q.tag;
  assign m_axis_tdata_o  = {4'b0000, out_res_q.blen, out_res_q.status,
                            out_res_q.commit, out_res_q.data};

endmodule

// ===== src/hrbt_checker.sv =====
`timescale 1ns / 1ps

module hrbt_checker import hrbt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [TdataW-1:0] m_axis_tdata_o,
  input logic [3:0]        m_axis_tuser_o
);

  logic [1:0]  commit;
  logic [1:0]  status;
  logic [31:0] blen;

  assign commit = m_axis_tdata_o[9:8];
  assign status = m_axis_tdata_o[11:10];
  assign blen   = m_axis_tdata_o[43:12];

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // Commits only fall on delimiter bytes
  a_commit_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (commit != CmtNone) |-> (m_axis_tuser_o == TagSkip))
    else $error("commit on a tagged field byte");

  // Decoded length only with the end of the headers
  a_blen_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (blen != 32'd0) |->
      (commit == CmtHdrEnd) && (status == StParsing))
    else $error("body length outside the end of the headers");

  // Policy and bad-length states only tag bytes as skipped
  a_term_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((status == StPolicy) || (status == StBadLen)) |->
      (m_axis_tuser_o == TagSkip) && (blen == 32'd0))
    else $error("terminal status on a tagged byte");

endmodule

bind http_request_byte_tokenizer_unit hrbt_checker u_hrbt_checker (.*);
